>>> hw/rtl/rbr_pkg.sv
package rbr_pkg;

	localparam logic [2:0] ACT_PUSH    = 3'd0;
	localparam logic [2:0] ACT_READ    = 3'd1;
	localparam logic [2:0] ACT_PEEK    = 3'd2;
	localparam logic [2:0] ACT_DISCARD = 3'd3;
	localparam logic [2:0] ACT_ALIGN   = 3'd4;

	localparam logic [4:0] MAX_LEN  = 5'd16;
	localparam logic [4:0] BYTE_LEN = 5'd8;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_in;
		logic [4:0] bit_len;
	} item_t;

	typedef struct packed {
		logic [15:0] bits_out;
		logic [11:0] bits_held;
		logic        overflow;
		logic        underflow;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_FIN   = 3'b100
	} state_t;

endpackage

>>> hw/rtl/rbr_ram.sv
module rbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/rbr_exec.sv
module rbr_exec #(
	parameter int RING_BYTES = 256
) (
	input  rbr_pkg::item_t                        item,
	input  logic [$clog2(RING_BYTES)-1:0]         rd_idx,
	input  logic [$clog2(RING_BYTES)-1:0]         wr_idx,
	input  logic [2:0]                            off,
	input  logic [$clog2(8*RING_BYTES+1)-1:0]     cnt,
	input  logic [23:0]                           win,
	output rbr_pkg::result_t                      res,
	output logic                                  push_ok,
	output logic [$clog2(RING_BYTES)-1:0]         rd_idx_nxt,
	output logic [$clog2(RING_BYTES)-1:0]         wr_idx_nxt,
	output logic [2:0]                            off_nxt,
	output logic [$clog2(8*RING_BYTES+1)-1:0]     cnt_nxt
);

	localparam int IW = $clog2(RING_BYTES);
	localparam int CW = $clog2(8*RING_BYTES+1);
	localparam logic [IW:0] RingLen = (IW+1)'(RING_BYTES);
	localparam logic [CW:0] FullLim = (CW+1)'(8*(RING_BYTES-1));

	logic [4:0]    len;
	logic [30:0]   sh;
	logic [15:0]   w16;
	logic          need;
	logic [4:0]    n;
	logic [4:0]    pos;
	logic [IW:0]   rd_sum;
	logic [IW:0]   wr_sum;
	logic [CW+4:0] n_ext;
	logic [CW+4:0] cnt_ext;
	logic [CW+4:0] cnt_sub;
	logic [CW+11:0] held_ext;

	always_comb begin
		len = (item.bit_len > rbr_pkg::MAX_LEN) ? rbr_pkg::MAX_LEN : item.bit_len;
		// window: top 16 bits below the bit offset of three ring bytes
		sh  = {7'd0, win} << off;
		w16 = sh[23:8];

		need = 1'b0;
		n    = 5'd0;

		res.bits_out  = 16'd0;
		res.overflow  = 1'b0;
		res.underflow = 1'b0;
		push_ok       = 1'b0;
		rd_idx_nxt    = rd_idx;
		wr_idx_nxt    = wr_idx;
		off_nxt       = off;
		cnt_nxt       = cnt;

		wr_sum = {1'b0, wr_idx} + (IW+1)'(1);
		if (wr_sum >= RingLen) begin
			wr_sum = wr_sum - RingLen;
		end

		case (item.action)
			rbr_pkg::ACT_PUSH: begin
				if (({1'b0, cnt} + (CW+1)'(off)) > FullLim) begin
					res.overflow = 1'b1;
				end else begin
					push_ok    = 1'b1;
					wr_idx_nxt = wr_sum[IW-1:0];
					cnt_nxt    = cnt + CW'(8);
				end
			end
			rbr_pkg::ACT_READ: begin
				if (len != 5'd0) begin
					res.bits_out = w16 >> (rbr_pkg::MAX_LEN - len);
					need         = 1'b1;
					n            = len;
				end
			end
			rbr_pkg::ACT_PEEK: begin
				res.bits_out = w16;
			end
			rbr_pkg::ACT_DISCARD: begin
				need = 1'b1;
				n    = len;
			end
			rbr_pkg::ACT_ALIGN: begin
				if (off != 3'd0) begin
					need = 1'b1;
					n    = rbr_pkg::BYTE_LEN - {2'b00, off};
				end
			end
			default: begin
			end
		endcase

		n_ext   = {{CW{1'b0}}, n};
		cnt_ext = {5'd0, cnt};
		cnt_sub = cnt_ext - n_ext;
		pos     = {2'b00, off} + n;
		rd_sum  = {1'b0, rd_idx} + (IW+1)'(pos[4:3]);
		if (rd_sum >= RingLen) begin
			rd_sum = rd_sum - RingLen;
		end

		if (need) begin
			if (n_ext > cnt_ext) begin
				// flush on underflow
				res.underflow = 1'b1;
				rd_idx_nxt    = wr_idx;
				off_nxt       = 3'd0;
				cnt_nxt       = '0;
			end else begin
				rd_idx_nxt = rd_sum[IW-1:0];
				off_nxt    = pos[2:0];
				cnt_nxt    = cnt_sub[CW-1:0];
			end
		end

		held_ext      = {12'd0, cnt_nxt};
		res.bits_held = held_ext[11:0];
	end

endmodule

>>> hw/rtl/ring_bitstream_reader.sv
// push, discard, align, zero-length read: idle, then the finish state, where the result is registered once
// the output register is free or being read; the next item is taken back in idle
// read and peek: idle, the fetch state, then the finish state; no new item is taken before idle again;
// the fetch makes three reads of the byte ring through its read port for the 24-bit window
// a result waiting in the output register does not stop the next item from being taken
// arst_n clears indices, bit offset, bit count and control; ring contents are not cleared
module ring_bitstream_reader #(
	parameter int RING_BYTES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  rbr_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output rbr_pkg::result_t result
);

	localparam int IW = $clog2(RING_BYTES);
	localparam int CW = $clog2(8*RING_BYTES+1);
	localparam logic [IW:0] RingLen = (IW+1)'(RING_BYTES);

	rbr_pkg::state_t  state_q;
	rbr_pkg::item_t   item_q;
	rbr_pkg::result_t out_q;
	rbr_pkg::result_t res;
	logic             out_valid_q;
	logic [IW-1:0]    rd_idx_q;
	logic [IW-1:0]    wr_idx_q;
	logic [2:0]       off_q;
	logic [CW-1:0]    cnt_q;
	logic [1:0]       fcnt_q;
	logic [23:0]      win_q;

	logic [IW-1:0]    rd_idx_nxt;
	logic [IW-1:0]    wr_idx_nxt;
	logic [2:0]       off_nxt;
	logic [CW-1:0]    cnt_nxt;
	logic             push_ok;
	logic             commit;
	logic             accept;
	logic             ram_we;
	logic             ram_re;
	logic [IW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;
	logic [IW:0]      addr_sum;

	assign item_ready   = (state_q == rbr_pkg::S_IDLE);
	assign accept       = item_valid && item_ready;
	assign commit       = (state_q == rbr_pkg::S_FIN) && (!out_valid_q || result_ready);
	assign ram_we       = commit && push_ok;
	assign ram_re       = (state_q == rbr_pkg::S_FETCH) && (fcnt_q != 2'd3);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// ring byte at read index plus fetch step, wrapped
	always_comb begin
		addr_sum = {1'b0, rd_idx_q} + (IW+1)'(fcnt_q);
		if (addr_sum >= RingLen) begin
			addr_sum = addr_sum - RingLen;
		end
		ram_raddr = addr_sum[IW-1:0];
	end

	rbr_ram #(
		.WIDTH (8),
		.DEPTH (RING_BYTES)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wr_idx_q),
		.wr_data (item_q.byte_in),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	rbr_exec #(
		.RING_BYTES (RING_BYTES)
	) u_exec (
		.item       (item_q),
		.rd_idx     (rd_idx_q),
		.wr_idx     (wr_idx_q),
		.off        (off_q),
		.cnt        (cnt_q),
		.win        (win_q),
		.res        (res),
		.push_ok    (push_ok),
		.rd_idx_nxt (rd_idx_nxt),
		.wr_idx_nxt (wr_idx_nxt),
		.off_nxt    (off_nxt),
		.cnt_nxt    (cnt_nxt)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if ((state_q == rbr_pkg::S_FETCH) && (fcnt_q != 2'd0)) begin
			win_q <= {win_q[15:0], ram_rdata};
		end
		if (commit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			off_q       <= 3'd0;
			cnt_q       <= '0;
			fcnt_q      <= 2'd0;
		end else begin
			// a new result may replace the one taken in the same cycle
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rbr_pkg::S_IDLE: begin
					if (accept) begin
						fcnt_q <= 2'd0;
						if ((item.action == rbr_pkg::ACT_PEEK) ||
						    ((item.action == rbr_pkg::ACT_READ) && (item.bit_len != 5'd0))) begin
							state_q <= rbr_pkg::S_FETCH;
						end else begin
							state_q <= rbr_pkg::S_FIN;
						end
					end
				end
				rbr_pkg::S_FETCH: begin
					fcnt_q <= fcnt_q + 2'd1;
					if (fcnt_q == 2'd3) begin
						state_q <= rbr_pkg::S_FIN;
					end
				end
				rbr_pkg::S_FIN: begin
					if (commit) begin
						rd_idx_q    <= rd_idx_nxt;
						wr_idx_q    <= wr_idx_nxt;
						off_q       <= off_nxt;
						cnt_q       <= cnt_nxt;
						state_q     <= rbr_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= rbr_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/tb_ring_bitstream_reader.sv
module tb_ring_bitstream_reader;

	localparam int RING_BYTES = 256;
	localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
	localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;

	typedef enum {MODE_MIX, MODE_FILL, MODE_DRAIN} stim_mode_t;

	class bit_ring_checker;
		logic [7:0]       ring [RING_BYTES];
		bit               written [RING_BYTES];
		int unsigned      wr_ptr;
		int unsigned      rd_ptr;
		int unsigned      bit_off;
		int unsigned      held_bits;
		rbr_pkg::result_t expected_results[$];
		int               fail_count;

		function new();
			wr_ptr = 0;
			rd_ptr = 0;
			bit_off = 0;
			held_bits = 0;
			fail_count = 0;
		endfunction

		// the three bytes under the window have all been stored at least once
		function bit window_ready();
			return written[rd_ptr] && written[(rd_ptr + 1) % RING_BYTES] &&
				written[(rd_ptr + 2) % RING_BYTES];
		endfunction

		function logic [15:0] window_bits();
			logic [23:0] w;
			logic [23:0] s;
			w = {ring[rd_ptr], ring[(rd_ptr + 1) % RING_BYTES], ring[(rd_ptr + 2) % RING_BYTES]};
			s = w >> (rbr_pkg::BYTE_LEN - bit_off);
			return s[15:0];
		endfunction

		// returns 1 when more bits are asked than held; the ring is then flushed
		function bit consume_bits(int unsigned n);
			int unsigned pos;
			if (n > held_bits) begin
				rd_ptr = wr_ptr;
				bit_off = 0;
				held_bits = 0;
				return 1'b1;
			end
			pos = bit_off + n;
			rd_ptr = (rd_ptr + (pos >> 3)) % RING_BYTES;
			bit_off = pos % 8;
			held_bits -= n;
			return 1'b0;
		endfunction

		function void take_item(rbr_pkg::item_t it);
			rbr_pkg::result_t exp;
			int unsigned      len;
			exp = '0;
			len = (it.bit_len > rbr_pkg::MAX_LEN) ? rbr_pkg::MAX_LEN : it.bit_len;
			case (it.action)
				rbr_pkg::ACT_PUSH: begin
					if (held_bits + bit_off > 8 * (RING_BYTES - 1)) begin
						exp.overflow = 1'b1;
					end else begin
						ring[wr_ptr] = it.byte_in;
						written[wr_ptr] = 1'b1;
						wr_ptr = (wr_ptr + 1) % RING_BYTES;
						held_bits += rbr_pkg::BYTE_LEN;
					end
				end
				rbr_pkg::ACT_READ: begin
					if (len != 0) begin
						exp.bits_out = window_bits() >> (rbr_pkg::MAX_LEN - len);
						exp.underflow = consume_bits(len);
					end
				end
				rbr_pkg::ACT_PEEK: exp.bits_out = window_bits();
				rbr_pkg::ACT_DISCARD: exp.underflow = consume_bits(len);
				rbr_pkg::ACT_ALIGN: begin
					if (bit_off != 0)
						exp.underflow = consume_bits(rbr_pkg::BYTE_LEN - bit_off);
				end
				default: ;
			endcase
			exp.bits_held = 12'(held_bits);
			expected_results.push_back(exp);
		endfunction

		function void check_result(rbr_pkg::result_t got);
			rbr_pkg::result_t exp;
			if (expected_results.size() == 0) begin
				$display("%0t: result %h with no transaction pending", $time, got);
				fail_count++;
				return;
			end
			exp = expected_results.pop_front();
			if (got.bits_out !== exp.bits_out) begin
				$display("%0t: bits_out expected %h actual %h", $time, exp.bits_out, got.bits_out);
				fail_count++;
			end
			if (got.bits_held !== exp.bits_held) begin
				$display("%0t: bits_held expected %0d actual %0d", $time, exp.bits_held,
					got.bits_held);
				fail_count++;
			end
			if (got.overflow !== exp.overflow) begin
				$display("%0t: overflow expected %b actual %b", $time, exp.overflow, got.overflow);
				fail_count++;
			end
			if (got.underflow !== exp.underflow) begin
				$display("%0t: underflow expected %b actual %b", $time, exp.underflow,
					got.underflow);
				fail_count++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	rbr_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	rbr_pkg::result_t result;
	bit               no_idle = 1'b0;

	bit_ring_checker ring_chk = new();

	ring_bitstream_reader #(
		.RING_BYTES(RING_BYTES)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			ring_chk.check_result(result);
	end

	// mostly short gaps, a few long ones, none at all during calm stretches
	function int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function rbr_pkg::item_t item_of(logic [2:0] action, logic [7:0] byte_in,
		logic [4:0] bit_len);
		rbr_pkg::item_t it;
		it.action = action;
		it.byte_in = byte_in;
		it.bit_len = bit_len;
		return it;
	endfunction

	// bit length mostly within what is held, otherwise anything the field allows
	function logic [4:0] pick_len();
		int unsigned lim;
		lim = (ring_chk.held_bits < rbr_pkg::MAX_LEN) ? ring_chk.held_bits : rbr_pkg::MAX_LEN;
		if (lim > 0 && $urandom_range(0, 9) < 8)
			return 5'($urandom_range(1, lim));
		return 5'($urandom_range(0, 31));
	endfunction

	function rbr_pkg::item_t next_item(stim_mode_t mode);
		rbr_pkg::item_t it;
		int             r;
		it = item_of(rbr_pkg::ACT_PUSH, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				if (r >= 95)
					it.action = rbr_pkg::ACT_READ;
			end
			MODE_DRAIN: begin
				if (r < 5)
					it.action = rbr_pkg::ACT_PUSH;
				else if (r < 10)
					it.action = 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
				else if (r < 50)
					it.action = rbr_pkg::ACT_READ;
				else if (r < 65)
					it.action = rbr_pkg::ACT_PEEK;
				else if (r < 85)
					it.action = rbr_pkg::ACT_DISCARD;
				else
					it.action = rbr_pkg::ACT_ALIGN;
			end
			default: begin
				if (r < 35)
					it.action = rbr_pkg::ACT_PUSH;
				else if (r < 40)
					it.action = 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
				else if (r < 60)
					it.action = rbr_pkg::ACT_READ;
				else if (r < 72)
					it.action = rbr_pkg::ACT_PEEK;
				else if (r < 88)
					it.action = rbr_pkg::ACT_DISCARD;
				else
					it.action = rbr_pkg::ACT_ALIGN;
			end
		endcase
		if (it.action == rbr_pkg::ACT_READ || it.action == rbr_pkg::ACT_DISCARD)
			it.bit_len = pick_len();
		// keep the window off ring slots that were never stored
		if ((it.action == rbr_pkg::ACT_READ || it.action == rbr_pkg::ACT_PEEK) &&
			!ring_chk.window_ready())
			it.action = rbr_pkg::ACT_PUSH;
		return it;
	endfunction

	task automatic send_item(rbr_pkg::item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		ring_chk.take_item(it);
	endtask

	task automatic wait_drained();
		while (ring_chk.expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(stim_mode_t mode, int count);
		rbr_pkg::item_t it;
		int             i;
		i = 0;
		while (i < count) begin
			it = next_item(mode);
			send_item(it);
			i++;
			// decoder pattern: look at the window, then drop the code length
			if (it.action == rbr_pkg::ACT_PEEK && mode != MODE_FILL &&
				$urandom_range(0, 1) == 1) begin
				send_item(item_of(rbr_pkg::ACT_DISCARD, 8'($urandom_range(0, 255)), pick_len()));
				i++;
			end
		end
	endtask

	initial begin : stall_rx
		int n;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		forever begin
			repeat ($urandom_range(100, 400)) @(posedge clk);
			no_idle = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		#10_000_000;
		$display("tb_ring_bitstream_reader: FAIL");
		$finish;
	end

	initial begin : stimulus
		rbr_pkg::item_t dir_items[$];
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'hFF, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'h00, 5'd31));
		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'hA5, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'h5A, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'h80, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'h01, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'hC3, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'h3C, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'h7E, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_PUSH, 8'h81, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_PEEK, 8'h00, 5'd0));
		// zero length read
		dir_items.push_back(item_of(rbr_pkg::ACT_READ, 8'h00, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_READ, 8'h00, 5'd1));
		dir_items.push_back(item_of(rbr_pkg::ACT_READ, 8'h00, rbr_pkg::MAX_LEN));
		// length above sixteen clamps
		dir_items.push_back(item_of(rbr_pkg::ACT_READ, 8'hFF, 5'd31));
		dir_items.push_back(item_of(rbr_pkg::ACT_DISCARD, 8'h00, 5'd3));
		dir_items.push_back(item_of(rbr_pkg::ACT_ALIGN, 8'h00, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_DISCARD, 8'h00, 5'd0));
		dir_items.push_back(item_of(rbr_pkg::ACT_DISCARD, 8'h00, 5'd28));
		dir_items.push_back(item_of(rbr_pkg::ACT_ALIGN, 8'h00, 5'd0));
		// discard sixteen of the 24 bits held
		dir_items.push_back(item_of(rbr_pkg::ACT_DISCARD, 8'h00, rbr_pkg::MAX_LEN));
		dir_items.push_back(item_of(rbr_pkg::ACT_ALIGN, 8'h00, 5'd0));
		dir_items.push_back(item_of(ACT_RSVD_FIRST, 8'h00, 5'd0));
		dir_items.push_back(item_of(ACT_RSVD_LAST, 8'hFF, 5'd31));
		foreach (dir_items[i])
			send_item(dir_items[i]);

		run_phase(MODE_MIX, 300);
		// mostly pushes, to drive the ring toward refusing bytes
		run_phase(MODE_FILL, 300);
		item_valid <= 1'b0;
		wait_drained();
		run_phase(MODE_DRAIN, 250);
		run_phase(MODE_MIX, 200);
		item_valid <= 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (ring_chk.fail_count == 0 && ring_chk.expected_results.size() == 0) begin
			$display("tb_ring_bitstream_reader: PASS");
		end else begin
			$display("tb_ring_bitstream_reader: FAIL");
		end
		$finish;
	end

endmodule
